// File: src/ffrs_pkg.sv
package ffrs_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int CB_W        = 21;
  localparam int SIZE_W      = 48;
  localparam int PROD_W      = COUNT_WIDTH + CB_W;
  localparam int ADDR_W      = 4;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [SIZE_W-1:0]      size_t48_t;

  // table entry formats
  localparam logic [1:0] KIND_FAT12 = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;
  localparam logic [1:0] KIND_FAT32 = 2'd2;

  // register indexes
  localparam logic [1:0] REG_FAT_KIND     = 2'd0;
  localparam logic [1:0] REG_SECT_PER_CL  = 2'd1;
  localparam logic [1:0] REG_BYTES_PER_SC = 2'd2;
  localparam logic [1:0] REG_MIN_FREE_RUN = 2'd3;

  localparam logic [1:0]  FAT_KIND_RST     = KIND_FAT16;
  localparam logic [7:0]  SECT_PER_CL_RST  = 8'd8;
  localparam logic [12:0] BYTES_PER_SC_RST = 13'd512;
  localparam logic [15:0] MIN_FREE_RUN_RST = 16'd100;

  localparam logic RES_RUN     = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  typedef struct packed {
    logic [1:0]  fat_kind;
    logic [7:0]  cl_sectors;
    logic [12:0] sect_bytes;
    logic [15:0] min_free_run;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E0,
    ST_E1,
    ST_PREP,
    ST_MTOT,
    ST_MUSED,
    ST_MLU,
    ST_SAT,
    ST_EM0,
    ST_EM1,
    ST_EMS
  } state_t;

  typedef enum logic [2:0] {
    SUM_NONE,
    SUM_PREP,
    SUM_TOT,
    SUM_USED,
    SUM_LU,
    SUM_SAT
  } sum_op_t;

  typedef enum logic [1:0] {
    OSEL_REC0,
    OSEL_REC1,
    OSEL_SUM
  } out_sel_t;

  typedef struct packed {
    logic     ld_item;
    logic     step0;
    logic     step1;
    sum_op_t  sum_op;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    logic two;
    logic end_flag;
    logic rec0_v;
    logic rec1_v;
    logic out_free;
  } status_t;

endpackage

// File: src/ffrs_regs.sv
module ffrs_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffrs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output ffrs_pkg::cfg_t               cfg
);
  import ffrs_pkg::*;

  logic [1:0] idx;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fat_kind     <= FAT_KIND_RST;
      cfg.cl_sectors   <= SECT_PER_CL_RST;
      cfg.sect_bytes   <= BYTES_PER_SC_RST;
      cfg.min_free_run <= MIN_FREE_RUN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_FAT_KIND:     cfg.fat_kind     <= pwdata[1:0];
        REG_SECT_PER_CL:  cfg.cl_sectors   <= pwdata[7:0];
        REG_BYTES_PER_SC: cfg.sect_bytes   <= pwdata[12:0];
        REG_MIN_FREE_RUN: cfg.min_free_run <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FAT_KIND:     prdata = {30'd0, cfg.fat_kind};
      REG_SECT_PER_CL:  prdata = {24'd0, cfg.cl_sectors};
      REG_BYTES_PER_SC: prdata = {19'd0, cfg.sect_bytes};
      REG_MIN_FREE_RUN: prdata = {16'd0, cfg.min_free_run};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// File: src/ffrs_ctrl.sv
module ffrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ffrs_pkg::status_t sts,
  output ffrs_pkg::cmd_t    cmd
);
  import ffrs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.ld_item  = 1'b0;
    cmd.step0    = 1'b0;
    cmd.step1    = 1'b0;
    cmd.sum_op   = SUM_NONE;
    cmd.out_load = 1'b0;
    cmd.out_sel  = OSEL_REC0;
    cmd.out_last = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_next  = ST_E0;
        end
      end
      ST_E0: begin
        cmd.step0 = 1'b1;
        if (sts.two) begin
          state_next = ST_E1;
        end else if (sts.end_flag) begin
          state_next = ST_PREP;
        end else begin
          state_next = ST_EM0;
        end
      end
      ST_E1: begin
        cmd.step1  = 1'b1;
        state_next = sts.end_flag ? ST_PREP : ST_EM0;
      end
      ST_PREP: begin
        cmd.sum_op = SUM_PREP;
        state_next = ST_MTOT;
      end
      ST_MTOT: begin
        cmd.sum_op = SUM_TOT;
        state_next = ST_MUSED;
      end
      ST_MUSED: begin
        cmd.sum_op = SUM_USED;
        state_next = ST_MLU;
      end
      ST_MLU: begin
        cmd.sum_op = SUM_LU;
        state_next = ST_SAT;
      end
      ST_SAT: begin
        cmd.sum_op = SUM_SAT;
        state_next = ST_EM0;
      end
      ST_EM0: begin
        if (!sts.rec0_v) begin
          state_next = ST_EM1;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_REC0;
          cmd.out_last = !sts.rec1_v && !sts.end_flag;
          state_next   = ST_EM1;
        end
      end
      ST_EM1: begin
        if (!sts.rec1_v) begin
          state_next = sts.end_flag ? ST_EMS : ST_IDLE;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_REC1;
          cmd.out_last = !sts.end_flag;
          state_next   = sts.end_flag ? ST_EMS : ST_IDLE;
        end
      end
      ST_EMS: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_SUM;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: src/ffrs_dp.sv
module ffrs_dp (
  input  logic                clk,
  input  logic                rst,
  input  ffrs_pkg::cfg_t      cfg,
  input  ffrs_pkg::cmd_t      cmd,
  output ffrs_pkg::status_t   sts,
  input  logic [31:0]         raw_entry,
  input  logic [1:0]          pair_valid,
  input  logic                table_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                result_kind,
  output logic [31:0]         run_first,
  output logic [31:0]         run_final,
  output logic [47:0]         total_bytes,
  output logic [47:0]         used_bytes,
  output logic [47:0]         last_used_bytes,
  output logic                last
);
  import ffrs_pkg::*;

  // latched item
  logic [31:0] raw_q;
  logic        two_q;
  logic        end_q;

  // scan state
  logic in_run;
  cnt_t run_start;
  cnt_t run_span;
  cnt_t entries_seen;
  cnt_t zero_entries;
  cnt_t last_used_index;

  // run records of the current item
  logic [1:0] rec_v;
  cnt_t       rec_first [2];
  cnt_t       rec_final [2];

  // summary arithmetic
  logic [CB_W-1:0]   cb;
  logic [PROD_W-1:0] prod;
  cnt_t              cnt_q;
  cnt_t              used_q;
  cnt_t              lu_q;
  size_t48_t         tot_b;
  size_t48_t         used_b;

  logic  step;
  logic  slot;
  logic  ent_nz;
  logic  ent_end;
  logic  close_hit;
  cnt_t  c_prev;
  cnt_t  mul_op;
  size_t48_t prod_sat;

  assign step    = cmd.step0 || cmd.step1;
  assign slot    = cmd.step1;
  assign ent_end = cmd.step1 ? end_q : (end_q && !two_q);
  assign c_prev  = entries_seen - cnt_t'(1);
  assign close_hit = in_run && (run_span > cnt_t'(cfg.min_free_run));
  assign prod_sat  = (|prod[PROD_W-1:SIZE_W]) ? {SIZE_W{1'b1}} : prod[SIZE_W-1:0];

  always_comb begin
    if (cmd.step1) begin
      ent_nz = |raw_q[23:12];
    end else begin
      case (cfg.fat_kind)
        KIND_FAT12: ent_nz = |raw_q[11:0];
        KIND_FAT16: ent_nz = |raw_q[15:0];
        default:    ent_nz = |raw_q[27:0];
      endcase
    end
  end

  always_comb begin
    case (cmd.sum_op)
      SUM_TOT:  mul_op = cnt_q;
      SUM_USED: mul_op = used_q;
      default:  mul_op = lu_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      raw_q <= raw_entry;
      two_q <= (cfg.fat_kind == KIND_FAT12) && pair_valid[1];
      end_q <= table_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run          <= 1'b0;
      run_start       <= '0;
      run_span        <= '0;
      entries_seen    <= '0;
      zero_entries    <= '0;
      last_used_index <= '0;
      rec_v           <= '0;
    end else begin
      if (cmd.ld_item) begin
        rec_v <= '0;
      end
      if (step) begin
        entries_seen <= entries_seen + cnt_t'(1);
        if (ent_nz) begin
          if (close_hit) begin
            rec_v[slot]     <= 1'b1;
            rec_first[slot] <= run_start;
            rec_final[slot] <= c_prev;
          end
          in_run          <= 1'b0;
          last_used_index <= entries_seen;
        end else begin
          zero_entries <= zero_entries + cnt_t'(1);
          if (!in_run) begin
            in_run    <= 1'b1;
            run_start <= entries_seen;
            run_span  <= '0;
          end else begin
            run_span <= run_span + cnt_t'(1);
          end
          if (ent_end) begin
            rec_v[slot]     <= 1'b1;
            rec_first[slot] <= in_run ? run_start : entries_seen;
            rec_final[slot] <= entries_seen;
          end
        end
      end
      if (cmd.sum_op == SUM_SAT) begin
        in_run          <= 1'b0;
        run_start       <= '0;
        run_span        <= '0;
        entries_seen    <= '0;
        zero_entries    <= '0;
        last_used_index <= '0;
      end
    end
  end

  // summary: saturating counts, then one shared multiplier, then clamp to 48 bits
  always_ff @(posedge clk) begin
    cb <= CB_W'(cfg.cl_sectors) * CB_W'(cfg.sect_bytes);
    case (cmd.sum_op)
      SUM_PREP: begin
        cnt_q <= (entries_seen >= cnt_t'(2)) ? entries_seen - cnt_t'(2) : '0;
        lu_q  <= (last_used_index >= cnt_t'(1)) ? last_used_index - cnt_t'(1) : '0;
      end
      SUM_TOT: begin
        prod   <= PROD_W'(mul_op * cb);
        used_q <= (cnt_q >= zero_entries) ? cnt_q - zero_entries : '0;
      end
      SUM_USED: begin
        tot_b <= prod_sat;
        prod  <= PROD_W'(mul_op * cb);
      end
      SUM_LU: begin
        used_b <= prod_sat;
        prod   <= PROD_W'(mul_op * cb);
      end
      default: ;
    endcase
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      last <= cmd.out_last;
      if (cmd.out_sel == OSEL_SUM) begin
        result_kind     <= RES_SUMMARY;
        run_first       <= '0;
        run_final       <= '0;
        total_bytes     <= tot_b;
        used_bytes      <= used_b;
        last_used_bytes <= prod_sat;
      end else begin
        result_kind     <= RES_RUN;
        run_first       <= 32'(rec_first[cmd.out_sel == OSEL_REC1]);
        run_final       <= 32'(rec_final[cmd.out_sel == OSEL_REC1]);
        total_bytes     <= '0;
        used_bytes      <= '0;
        last_used_bytes <= '0;
      end
    end
  end

  assign sts.two      = two_q;
  assign sts.end_flag = end_q;
  assign sts.rec0_v   = rec_v[0];
  assign sts.rec1_v   = rec_v[1];
  assign sts.out_free = !out_valid || out_ready;

endmodule

// File: src/fat_free_run_scanner.sv
// Each item is decoded one table entry per cycle (a second only for a FAT12 pair),
// then its run records leave through the output register, one per cycle when taken.
// An item that ends the table runs the summary states PREP, MTOT, MUSED, MLU and SAT
// before its records, using the one shared cluster-size multiplier three times, and
// loads the summary after them. New items are taken only in the idle state.
// Reset (rst, sync, high) clears the scan state and output valid, restores defaults.
module fat_free_run_scanner (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffrs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [31:0]                  raw_entry,
  input  logic [1:0]                   pair_valid,
  input  logic                         table_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         result_kind,
  output logic [31:0]                  run_first,
  output logic [31:0]                  run_final,
  output logic [47:0]                  total_bytes,
  output logic [47:0]                  used_bytes,
  output logic [47:0]                  last_used_bytes,
  output logic                         last
);
  import ffrs_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t sts;

  ffrs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffrs_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .raw_entry       (raw_entry),
    .pair_valid      (pair_valid),
    .table_end       (table_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .run_first       (run_first),
    .run_final       (run_final),
    .total_bytes     (total_bytes),
    .used_bytes      (used_bytes),
    .last_used_bytes (last_used_bytes),
    .last            (last)
  );

endmodule
